>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes and types of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [4:0] CMD_NONE     = 5'd0;
    localparam logic [4:0] CMD_LOAD     = 5'd1;
    localparam logic [4:0] CMD_WLOAD_A  = 5'd2;
    localparam logic [4:0] CMD_WLOAD_B  = 5'd3;
    localparam logic [4:0] CMD_WZERO    = 5'd4;
    localparam logic [4:0] CMD_GCD_W    = 5'd5;
    localparam logic [4:0] CMD_GCD_D    = 5'd6;
    localparam logic [4:0] CMD_DIV_N    = 5'd7;
    localparam logic [4:0] CMD_STN_DIVD = 5'd8;
    localparam logic [4:0] CMD_STORE_D  = 5'd9;
    localparam logic [4:0] CMD_SAVE_A   = 5'd10;
    localparam logic [4:0] CMD_SAVE_B   = 5'd11;
    localparam logic [4:0] CMD_DIV_Q1   = 5'd12;
    localparam logic [4:0] CMD_STQ1_Q2  = 5'd13;
    localparam logic [4:0] CMD_STORE_Q2 = 5'd14;
    localparam logic [4:0] CMD_MUL_L    = 5'd15;
    localparam logic [4:0] CMD_MUL_TA   = 5'd16;
    localparam logic [4:0] CMD_MUL_TB   = 5'd17;
    localparam logic [4:0] CMD_MUL_NN   = 5'd18;
    localparam logic [4:0] CMD_MUL_DD   = 5'd19;
    localparam logic [4:0] CMD_MUL_NBD  = 5'd20;
    localparam logic [4:0] CMD_MUL_DBN  = 5'd21;
    localparam logic [4:0] CMD_COMBINE  = 5'd22;
    localparam logic [4:0] CMD_OUT      = 5'd23;

    typedef struct packed {
        logic [4:0] code;
        logic [1:0] status;
    } rau_cmd_t;

    typedef struct packed {
        logic zero_den;
        logic w_zero;
        logic b_zero;
        logic ovf;
        logic gcd_busy;
        logic div_busy;
        logic out_busy;
        logic [1:0] op;
    } rau_stat_t;

endpackage

`default_nettype wire

>>> rtl/rau_if.sv
// ----------------------------------------------------------------------------
// rau_req_if / rau_rsp_if
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;

    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

`default_nettype wire

>>> rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd of two nonzero words, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_gcd #(
    parameter int D = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [D-1:0] x,
    input  wire logic [D-1:0] y,
    output logic              busy,
    output logic [D-1:0]      g
);

    localparam int KW = $clog2(D);

    logic          busy_reg;
    logic [D-1:0]  x_reg;
    logic [D-1:0]  y_reg;
    logic [KW-1:0] k_reg;
    logic [D-1:0]  g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && x_reg == y_reg)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            k_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (x_reg == y_reg)
            begin
                g_reg <= x_reg << k_reg;
            end
            else if (!x_reg[0] && !y_reg[0])
            begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!x_reg[0])
            begin
                x_reg <= x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_reg <= y_reg >> 1;
            end
            else if (x_reg > y_reg)
            begin
                x_reg <= x_reg - y_reg;
            end
            else
            begin
                y_reg <= y_reg - x_reg;
            end
        end
    end

    assign busy = busy_reg;
    assign g    = g_reg;

endmodule

`default_nettype wire

>>> rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div #(
    parameter int D = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [D-1:0] dividend,
    input  wire logic [D-1:0] divisor,
    output logic              busy,
    output logic [D-1:0]      quot
);

    localparam int KW = $clog2(D + 1);

    logic          busy_reg;
    logic [KW-1:0] cnt_reg;
    logic [D-1:0]  rem_reg;
    logic [D-1:0]  quo_reg;
    logic [D-1:0]  dvs_reg;
    logic [D:0]    shifted;
    logic [D:0]    diff;

    assign shifted = {rem_reg, quo_reg[D-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= KW'(D);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == KW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[D])
            begin
                rem_reg <= diff[D-1:0];
                quo_reg <= {quo_reg[D-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[D-1:0];
                quo_reg <= {quo_reg[D-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

>>> rtl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand and working registers, multiplier, gcd and divider units,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_dp
    import rau_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rau_cmd_t           cmd,
    output rau_stat_t               stat,
    input  wire logic [1:0]         req_type,
    input  wire logic signed [31:0] a_num,
    input  wire logic signed [31:0] a_den,
    input  wire logic signed [31:0] b_num,
    input  wire logic signed [31:0] b_den,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      res_num,
    output logic [30:0]             res_den,
    output logic [1:0]              status
);

    localparam int D = 2 * W;
    localparam logic [D-1:0] LIMIT = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};

    logic [W-1:0] an_raw, ad_raw, bn_raw, bd_raw;
    logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;

    logic [1:0]   op_reg;
    logic         zero_den_reg;
    logic         an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;

    logic         a_neg_reg, b_neg_reg;
    logic [W-1:0] a_n_reg, a_d_reg, b_n_reg, b_d_reg;
    logic [W-1:0] q1_reg, q2_reg;
    logic [D-1:0] ta_reg, tb_reg;
    logic         w_neg_reg;
    logic [D-1:0] w_n_reg, w_d_reg;

    logic         out_valid_reg;
    logic [31:0]  res_num_reg;
    logic [30:0]  res_den_reg;
    logic [1:0]   status_reg;

    logic [W-1:0] mul_a, mul_b;
    logic [D-1:0] prod;
    logic         gcd_start, gcd_busy;
    logic [D-1:0] gcd_x, gcd_y, g;
    logic         div_start, div_busy;
    logic [D-1:0] div_n, div_d, quot;
    logic         bneg_eff;
    logic [31:0]  mag32;

    assign an_raw = a_num[W-1:0];
    assign ad_raw = a_den[W-1:0];
    assign bn_raw = b_num[W-1:0];
    assign bd_raw = b_den[W-1:0];
    assign an_mag = an_raw[W-1] ? (~an_raw + 1'b1) : an_raw;
    assign ad_mag = ad_raw[W-1] ? (~ad_raw + 1'b1) : ad_raw;
    assign bn_mag = bn_raw[W-1] ? (~bn_raw + 1'b1) : bn_raw;
    assign bd_mag = bd_raw[W-1] ? (~bd_raw + 1'b1) : bd_raw;

    always_comb
    begin
        mul_a = a_n_reg;
        mul_b = b_n_reg;
        case (cmd.code)
            CMD_MUL_L:   begin mul_a = q1_reg;  mul_b = b_d_reg; end
            CMD_MUL_TA:  begin mul_a = a_n_reg; mul_b = q2_reg;  end
            CMD_MUL_TB:  begin mul_a = b_n_reg; mul_b = q1_reg;  end
            CMD_MUL_DD:  begin mul_a = a_d_reg; mul_b = b_d_reg; end
            CMD_MUL_NBD: begin mul_a = a_n_reg; mul_b = b_d_reg; end
            CMD_MUL_DBN: begin mul_a = a_d_reg; mul_b = b_n_reg; end
            default:     begin mul_a = a_n_reg; mul_b = b_n_reg; end
        endcase
    end

    assign prod = D'(mul_a) * D'(mul_b);

    assign gcd_start = (cmd.code == CMD_GCD_W) || (cmd.code == CMD_GCD_D);
    assign gcd_x     = (cmd.code == CMD_GCD_D) ? D'(a_d_reg) : w_n_reg;
    assign gcd_y     = (cmd.code == CMD_GCD_D) ? D'(b_d_reg) : w_d_reg;

    rau_gcd #(.D(D)) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x     (gcd_x),
        .y     (gcd_y),
        .busy  (gcd_busy),
        .g     (g)
    );

    always_comb
    begin
        div_start = 1'b1;
        div_n     = w_n_reg;
        case (cmd.code)
            CMD_DIV_N:    div_n = w_n_reg;
            CMD_STN_DIVD: div_n = w_d_reg;
            CMD_DIV_Q1:   div_n = D'(a_d_reg);
            CMD_STQ1_Q2:  div_n = D'(b_d_reg);
            default:      div_start = 1'b0;
        endcase
    end

    assign div_d = g;

    rau_div #(.D(D)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .quot     (quot)
    );

    assign bneg_eff = (op_reg == OP_SUB) ? ((b_n_reg != '0) && !b_neg_reg) : b_neg_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.code)
            CMD_LOAD:
            begin
                op_reg       <= req_type;
                zero_den_reg <= (ad_mag == '0) || (bd_mag == '0);
                an_s_reg     <= an_raw[W-1];
                ad_s_reg     <= ad_raw[W-1];
                bn_s_reg     <= bn_raw[W-1];
                bd_s_reg     <= bd_raw[W-1];
                an_reg       <= an_mag;
                ad_reg       <= ad_mag;
                bn_reg       <= bn_mag;
                bd_reg       <= bd_mag;
            end
            CMD_WLOAD_A:
            begin
                w_n_reg   <= D'(an_reg);
                w_d_reg   <= D'(ad_reg);
                w_neg_reg <= an_s_reg ^ ad_s_reg;
            end
            CMD_WLOAD_B:
            begin
                w_n_reg   <= D'(bn_reg);
                w_d_reg   <= D'(bd_reg);
                w_neg_reg <= bn_s_reg ^ bd_s_reg;
            end
            CMD_WZERO:
            begin
                w_d_reg   <= D'(1);
                w_neg_reg <= 1'b0;
            end
            CMD_STN_DIVD: w_n_reg <= quot;
            CMD_STORE_D:  w_d_reg <= quot;
            CMD_SAVE_A:
            begin
                a_n_reg   <= w_n_reg[W-1:0];
                a_d_reg   <= w_d_reg[W-1:0];
                a_neg_reg <= w_neg_reg;
            end
            CMD_SAVE_B:
            begin
                b_n_reg   <= w_n_reg[W-1:0];
                b_d_reg   <= w_d_reg[W-1:0];
                b_neg_reg <= w_neg_reg;
            end
            CMD_STQ1_Q2:  q1_reg <= quot[W-1:0];
            CMD_STORE_Q2: q2_reg <= quot[W-1:0];
            CMD_MUL_L:    w_d_reg <= prod;
            CMD_MUL_TA:   ta_reg <= prod;
            CMD_MUL_TB:   tb_reg <= prod;
            CMD_MUL_NN,
            CMD_MUL_NBD:
            begin
                w_n_reg   <= prod;
                w_neg_reg <= a_neg_reg ^ b_neg_reg;
            end
            CMD_MUL_DD,
            CMD_MUL_DBN:  w_d_reg <= prod;
            CMD_COMBINE:
            begin
                if (a_neg_reg == bneg_eff)
                begin
                    w_n_reg   <= ta_reg + tb_reg;
                    w_neg_reg <= a_neg_reg;
                end
                else if (ta_reg >= tb_reg)
                begin
                    w_n_reg   <= ta_reg - tb_reg;
                    w_neg_reg <= a_neg_reg;
                end
                else
                begin
                    w_n_reg   <= tb_reg - ta_reg;
                    w_neg_reg <= bneg_eff;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign mag32 = 32'(w_n_reg[W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.code == CMD_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.code == CMD_OUT)
        begin
            status_reg <= cmd.status;
            if (cmd.status == ST_OK)
            begin
                res_num_reg <= w_neg_reg ? (~mag32 + 1'b1) : mag32;
                res_den_reg <= 31'(w_d_reg[W-1:0]);
            end
            else
            begin
                res_num_reg <= '0;
                res_den_reg <= '0;
            end
        end
    end

    assign stat.zero_den = zero_den_reg;
    assign stat.w_zero   = (w_n_reg == '0);
    assign stat.b_zero   = (b_n_reg == '0);
    assign stat.ovf      = (w_n_reg > LIMIT) || (w_d_reg > LIMIT);
    assign stat.gcd_busy = gcd_busy;
    assign stat.div_busy = div_busy;
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign stat.op       = op_reg;

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

>>> rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: normalizes both operands, runs the operation, reduces the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire rau_stat_t stat,
    output rau_cmd_t       cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHK   = 5'd1;
    localparam logic [4:0] S_RST   = 5'd2;
    localparam logic [4:0] S_RGCD  = 5'd3;
    localparam logic [4:0] S_RDN   = 5'd4;
    localparam logic [4:0] S_RDD   = 5'd5;
    localparam logic [4:0] S_REND  = 5'd6;
    localparam logic [4:0] S_LB    = 5'd7;
    localparam logic [4:0] S_OP    = 5'd8;
    localparam logic [4:0] S_MD    = 5'd9;
    localparam logic [4:0] S_MDD   = 5'd10;
    localparam logic [4:0] S_AG    = 5'd11;
    localparam logic [4:0] S_Q1    = 5'd12;
    localparam logic [4:0] S_Q2    = 5'd13;
    localparam logic [4:0] S_ML    = 5'd14;
    localparam logic [4:0] S_MTA   = 5'd15;
    localparam logic [4:0] S_MTB   = 5'd16;
    localparam logic [4:0] S_CMB   = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;

    localparam logic [1:0] RET_A = 2'd0;
    localparam logic [1:0] RET_B = 2'd1;
    localparam logic [1:0] RET_R = 2'd2;

    logic [4:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;
    logic [1:0] st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_A;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        st_next    = st_reg;
        cmd.code   = CMD_NONE;
        cmd.status = st_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.code   = CMD_LOAD;
                    st_next    = ST_OK;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.zero_den)
                begin
                    st_next    = ST_ZERO_DEN;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.code   = CMD_WLOAD_A;
                    ret_next   = RET_A;
                    state_next = S_RST;
                end
            end
            S_RST:
            begin
                if (stat.w_zero)
                begin
                    cmd.code   = CMD_WZERO;
                    state_next = S_REND;
                end
                else
                begin
                    cmd.code   = CMD_GCD_W;
                    state_next = S_RGCD;
                end
            end
            S_RGCD:
            begin
                if (!stat.gcd_busy)
                begin
                    cmd.code   = CMD_DIV_N;
                    state_next = S_RDN;
                end
            end
            S_RDN:
            begin
                if (!stat.div_busy)
                begin
                    cmd.code   = CMD_STN_DIVD;
                    state_next = S_RDD;
                end
            end
            S_RDD:
            begin
                if (!stat.div_busy)
                begin
                    cmd.code   = CMD_STORE_D;
                    state_next = S_REND;
                end
            end
            S_REND:
            begin
                case (ret_reg)
                    RET_A:
                    begin
                        cmd.code   = CMD_SAVE_A;
                        state_next = S_LB;
                    end
                    RET_B:
                    begin
                        cmd.code   = CMD_SAVE_B;
                        state_next = S_OP;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_LB:
            begin
                cmd.code   = CMD_WLOAD_B;
                ret_next   = RET_B;
                state_next = S_RST;
            end
            S_OP:
            begin
                case (stat.op)
                    OP_MUL:
                    begin
                        cmd.code   = CMD_MUL_NN;
                        state_next = S_MD;
                    end
                    OP_DIV:
                    begin
                        if (stat.b_zero)
                        begin
                            st_next    = ST_DIV_ZERO;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.code   = CMD_MUL_NBD;
                            state_next = S_MDD;
                        end
                    end
                    default:
                    begin
                        cmd.code   = CMD_GCD_D;
                        state_next = S_AG;
                    end
                endcase
            end
            S_MD:
            begin
                cmd.code   = CMD_MUL_DD;
                ret_next   = RET_R;
                state_next = S_RST;
            end
            S_MDD:
            begin
                cmd.code   = CMD_MUL_DBN;
                ret_next   = RET_R;
                state_next = S_RST;
            end
            S_AG:
            begin
                if (!stat.gcd_busy)
                begin
                    cmd.code   = CMD_DIV_Q1;
                    state_next = S_Q1;
                end
            end
            S_Q1:
            begin
                if (!stat.div_busy)
                begin
                    cmd.code   = CMD_STQ1_Q2;
                    state_next = S_Q2;
                end
            end
            S_Q2:
            begin
                if (!stat.div_busy)
                begin
                    cmd.code   = CMD_STORE_Q2;
                    state_next = S_ML;
                end
            end
            S_ML:
            begin
                cmd.code   = CMD_MUL_L;
                state_next = S_MTA;
            end
            S_MTA:
            begin
                cmd.code   = CMD_MUL_TA;
                state_next = S_MTB;
            end
            S_MTB:
            begin
                cmd.code   = CMD_MUL_TB;
                state_next = S_CMB;
            end
            S_CMB:
            begin
                cmd.code   = CMD_COMBINE;
                ret_next   = RET_R;
                state_next = S_RST;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.code   = CMD_OUT;
                    cmd.status = (st_reg == ST_OK && stat.ovf) ? ST_OVERFLOW : st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/rational_arithmetic_unit_top.sv
// Work per item: up to eight divisions in the bit-serial divider plus binary
//   gcd runs of one step a cycle; an item with a zero denominator runs neither.
// Throughput: one item at a time; the next item is taken once the result sits in
//   the output register.
// Reset: rst_n asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact fraction add, subtract, multiply and divide with reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    rau_req_if.sink  req,
    rau_rsp_if.source rsp
);

    rau_cmd_t  cmd;
    rau_stat_t stat;
    logic      in_ready;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rau_dp #(.W(OPERAND_WIDTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_type  (req.req_type),
        .a_num     (req.a_num),
        .a_den     (req.a_den),
        .b_num     (req.b_num),
        .b_den     (req.b_den),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .res_num   (rsp.res_num),
        .res_den   (rsp.res_den),
        .status    (rsp.status)
    );

    assign req.ready = in_ready;

endmodule

`default_nettype wire

>>> rtl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_checker
    import rau_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] res_num,
    input wire logic [30:0] res_den,
    input wire logic [1:0]  status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while previous item in work");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> res_num == '0 && res_den == '0)
        else $error("error result carries a value");

    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_OK |-> res_den != '0)
        else $error("zero denominator in result");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .res_num   (rsp.res_num),
    .res_den   (rsp.res_den),
    .status    (rsp.status)
);

`default_nettype wire
